// ----- rtl/core/hsv_pkg.sv -----
// ----------------------------------------------------------------------------
// hsv_pkg
// shared types and constants for the hsv to rgb converter pipeline
// ----------------------------------------------------------------------------
package hsv_pkg;

  // input beat: one colour in hsv form
  typedef struct packed {
    logic [15:0] hue_centideg;
    logic [6:0]  sat_pct;
    logic [6:0]  val_pct;
  } hsv_t;

  // result beat: one colour in rgb form
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // 60 degree hue sectors
  typedef enum logic [2:0] {
    SEC_RED_YELLOW    = 3'd0,
    SEC_YELLOW_GREEN  = 3'd1,
    SEC_GREEN_CYAN    = 3'd2,
    SEC_CYAN_BLUE     = 3'd3,
    SEC_BLUE_MAGENTA  = 3'd4,
    SEC_MAGENTA_RED   = 3'd5
  } sector_t;

  // lane order inside the numerator and code vectors
  localparam int unsigned LANE_MAX = 0;
  localparam int unsigned LANE_MID = 1;
  localparam int unsigned LANE_MIN = 2;
  localparam int unsigned LANES    = 3;

  localparam logic [15:0] FULL_TURN   = 16'd36000;
  localparam logic [12:0] SECTOR_SPAN = 13'd6000;
  localparam logic [6:0]  PCT_MAX     = 7'd100;

  // start of each sector in centidegrees
  localparam logic [5:0][15:0] SECTOR_BASE = {
    16'd30000, 16'd24000, 16'd18000, 16'd12000, 16'd6000, 16'd0
  };

  // value scale: one percent of value in units of 1/60e6
  localparam logic [19:0] VAL_UNIT = 20'd600000;

  // code = floor(n * 255 / 60e6) = floor(floor(n * 17 / 256) / 15625)
  localparam int unsigned RECIP_SHIFT = 36;
  localparam logic [22:0] RECIP       = 23'd4398047;  // ceil(2^36 / 15625)

  // hue sector, mid-component weight and chroma product
  typedef struct packed {
    sector_t     sector;
    logic [12:0] frac;   // 6000 - distance from sector midpoint fold
    logic [13:0] sv;     // sat * val
    logic [6:0]  val;
  } prep_t;

  // numerators over 60e6 for the largest, middle and smallest component
  typedef struct packed {
    sector_t               sector;
    logic [LANES-1:0][25:0] n;
  } num_t;

  // 8-bit codes of the three components
  typedef struct packed {
    sector_t               sector;
    logic [LANES-1:0][7:0] code;
  } code_t;

endpackage

// ----- rtl/core/hsv_prep.sv -----
// ----------------------------------------------------------------------------
// hsv_prep
// input range folding, sector split and chroma product (two stages)
// ----------------------------------------------------------------------------
module hsv_prep (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  hsv_pkg::hsv_t  in_beat,
  output logic           out_valid,
  output hsv_pkg::prep_t out_beat
);
  import hsv_pkg::*;

  logic        valid1;
  logic [15:0] hue1;
  logic [6:0]  sat1;
  logic [6:0]  val1;

  sector_t     sector;
  logic [15:0] offset;
  logic [12:0] rem;

  // stage 1: wrap hue, clamp percentages
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else begin
      valid1 <= in_valid;
    end
    hue1 <= (in_beat.hue_centideg >= FULL_TURN) ? in_beat.hue_centideg - FULL_TURN
                                                : in_beat.hue_centideg;
    sat1 <= (in_beat.sat_pct > PCT_MAX) ? PCT_MAX : in_beat.sat_pct;
    val1 <= (in_beat.val_pct > PCT_MAX) ? PCT_MAX : in_beat.val_pct;
  end

  // stage 2: sector and position inside it
  always_comb begin
    if (hue1 >= SECTOR_BASE[5]) begin
      sector = SEC_MAGENTA_RED;
    end else if (hue1 >= SECTOR_BASE[4]) begin
      sector = SEC_BLUE_MAGENTA;
    end else if (hue1 >= SECTOR_BASE[3]) begin
      sector = SEC_CYAN_BLUE;
    end else if (hue1 >= SECTOR_BASE[2]) begin
      sector = SEC_GREEN_CYAN;
    end else if (hue1 >= SECTOR_BASE[1]) begin
      sector = SEC_YELLOW_GREEN;
    end else begin
      sector = SEC_RED_YELLOW;
    end
    offset = hue1 - SECTOR_BASE[sector];
    rem    = offset[12:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= valid1;
    end
    out_beat.sector <= sector;
    // odd sectors fall from full chroma, even sectors rise
    out_beat.frac   <= sector[0] ? SECTOR_SPAN - rem : rem;
    out_beat.sv     <= 14'(sat1) * 14'(val1);
    out_beat.val    <= val1;
  end

endmodule

// ----- rtl/core/hsv_scale.sv -----
// ----------------------------------------------------------------------------
// hsv_scale
// component numerators over the common denominator 60e6 (two stages)
// ----------------------------------------------------------------------------
module hsv_scale (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  hsv_pkg::prep_t in_beat,
  output logic           out_valid,
  output hsv_pkg::num_t  out_beat
);
  import hsv_pkg::*;

  logic        valid3;
  sector_t     sector3;
  logic [25:0] v_full;
  logic [25:0] c_full;
  logic [25:0] x_full;
  logic [25:0] n_min;

  // stage 3: value, chroma and secondary products
  always_ff @(posedge clk) begin
    if (rst) begin
      valid3 <= 1'b0;
    end else begin
      valid3 <= in_valid;
    end
    sector3 <= in_beat.sector;
    v_full  <= 26'(in_beat.val) * 26'(VAL_UNIT);
    c_full  <= 26'(in_beat.sv) * 26'(SECTOR_SPAN);
    x_full  <= 26'(in_beat.sv) * 26'(in_beat.frac);
  end

  // offset m = v - c never goes negative since s <= 100
  assign n_min = v_full - c_full;

  // stage 4: max = c + m = v, mid = x + m, min = m
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= valid3;
    end
    out_beat.sector      <= sector3;
    out_beat.n[LANE_MAX] <= v_full;
    out_beat.n[LANE_MID] <= n_min + x_full;
    out_beat.n[LANE_MIN] <= n_min;
  end

endmodule

// ----- rtl/core/hsv_code.sv -----
// ----------------------------------------------------------------------------
// hsv_code
// scales numerators to 8-bit codes, floor(n * 255 / 60e6) (two stages)
// ----------------------------------------------------------------------------
module hsv_code (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  hsv_pkg::num_t  in_beat,
  output logic           out_valid,
  output hsv_pkg::code_t out_beat
);
  import hsv_pkg::*;

  logic                   valid5;
  sector_t                sector5;
  logic [LANES-1:0][30:0] p17;
  logic [LANES-1:0][21:0] a5;
  logic [LANES-1:0][44:0] prod;

  // n * 17 as shift and add
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      p17[i] = {1'b0, in_beat.n[i], 4'b0000} + 31'(in_beat.n[i]);
    end
  end

  // stage 5: drop the power-of-two part of 4e6
  always_ff @(posedge clk) begin
    if (rst) begin
      valid5 <= 1'b0;
    end else begin
      valid5 <= in_valid;
    end
    sector5 <= in_beat.sector;
    for (int i = 0; i < LANES; i++) begin
      a5[i] <= p17[i][29:8];
    end
  end

  // divide by 15625 through the reciprocal, exact for a below 2^22
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      prod[i] = 45'(a5[i]) * 45'(RECIP);
    end
  end

  // stage 6
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= valid5;
    end
    out_beat.sector <= sector5;
    for (int i = 0; i < LANES; i++) begin
      out_beat.code[i] <= prod[i][RECIP_SHIFT+7:RECIP_SHIFT];
    end
  end

endmodule

// ----- rtl/core/hsv_to_rgb_converter_unit.sv -----
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_unit
// hsv colour to 8-bit rgb, exact rational arithmetic, fully pipelined
// ----------------------------------------------------------------------------
// usage: present a colour on hsv and raise start; busy is always low, so a
// beat is taken on every cycle that start is high. the rgb result comes out
// once its beat has passed through the pipeline, on rgb with done high for exactly
// one cycle. the receiver cannot hold results off, so it must take every
// result in the cycle it appears. one beat per clock is sustained; the
// seven-stage register pipeline (range fold, sector split, three products,
// numerator sums, scale by 17/256, reciprocal divide, channel select) sets
// the latency. hue at or above 36000 wraps once by 36000, saturation and
// value above 100 clamp to 100. each channel is floor(255 * (comp + m)),
// truncated exactly, never above 255.
module hsv_to_rgb_converter_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  hsv_pkg::hsv_t hsv,
  output logic          done,
  output hsv_pkg::rgb_t rgb
);
  import hsv_pkg::*;

  // the pipeline never stalls, so every start is a taken beat
  logic  accept;

  logic  prep_valid;
  prep_t prep_beat;
  logic  num_valid;
  num_t  num_beat;
  logic  code_valid;
  code_t code_beat;

  logic [7:0] c_max;
  logic [7:0] c_mid;
  logic [7:0] c_min;
  rgb_t       rgb_next;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // stages 1-2: hue wrap, clamps, sector, chroma product
  hsv_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_beat   (hsv),
    .out_valid (prep_valid),
    .out_beat  (prep_beat)
  );

  // stages 3-4: numerators of the max, mid and min components
  hsv_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .in_beat   (prep_beat),
    .out_valid (num_valid),
    .out_beat  (num_beat)
  );

  // stages 5-6: numerators to 8-bit codes
  hsv_code u_code (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (num_valid),
    .in_beat   (num_beat),
    .out_valid (code_valid),
    .out_beat  (code_beat)
  );

  assign c_max = code_beat.code[LANE_MAX];
  assign c_mid = code_beat.code[LANE_MID];
  assign c_min = code_beat.code[LANE_MIN];

  // stage 7: the sector decides which channel gets which component
  always_comb begin
    case (code_beat.sector)
      SEC_RED_YELLOW: begin
        rgb_next = '{red: c_max, green: c_mid, blue: c_min};
      end
      SEC_YELLOW_GREEN: begin
        rgb_next = '{red: c_mid, green: c_max, blue: c_min};
      end
      SEC_GREEN_CYAN: begin
        rgb_next = '{red: c_min, green: c_max, blue: c_mid};
      end
      SEC_CYAN_BLUE: begin
        rgb_next = '{red: c_min, green: c_mid, blue: c_max};
      end
      SEC_BLUE_MAGENTA: begin
        rgb_next = '{red: c_mid, green: c_min, blue: c_max};
      end
      default: begin
        // magenta to red
        rgb_next = '{red: c_max, green: c_min, blue: c_mid};
      end
    endcase
  end

  // output register: one-cycle strobe per result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= code_valid;
    end
    rgb <= rgb_next;
  end

endmodule

// ----- rtl/core/hsv_checker.sv -----
// ----------------------------------------------------------------------------
// hsv_checker
// port-level checks of the converter: latency and a few colour identities
// ----------------------------------------------------------------------------
module hsv_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input hsv_pkg::hsv_t hsv,
  input logic          done,
  input hsv_pkg::rgb_t rgb
);
  import hsv_pkg::*;

  localparam int unsigned LATENCY = 7;

  // every taken beat gives a result after the fixed latency
  a_beat_to_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("result missing after accepted beat");

  // no result without a beat taken the fixed latency before
  a_result_from_beat: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without matching beat");

  // zero value gives black
  a_black: assert property (@(posedge clk) disable iff (rst)
    (done && $past(hsv.val_pct == 7'd0, LATENCY))
      |-> (rgb.red == 8'd0 && rgb.green == 8'd0 && rgb.blue == 8'd0))
    else $error("zero value did not give black");

  // zero saturation gives a grey
  a_grey: assert property (@(posedge clk) disable iff (rst)
    (done && $past(hsv.sat_pct == 7'd0, LATENCY))
      |-> (rgb.red == rgb.green && rgb.green == rgb.blue))
    else $error("zero saturation did not give grey");

endmodule

bind hsv_to_rgb_converter_unit hsv_checker u_hsv_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .hsv   (hsv),
  .done  (done),
  .rgb   (rgb)
);

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// hsv to rgb converter check: a queue of colour beats feeds a falling-edge
// driver, and a rising-edge monitor predicts each rgb result exactly and
// compares it field by field with what the converter returns
// ----------------------------------------------------------------------------
module testbench;
  import hsv_pkg::*;

  // stimulus sizes
  localparam int unsigned RANDOM_BEATS = 1230;
  localparam int unsigned QUIET_TAIL   = 150;  // last beats go back to back
  localparam int unsigned GAP_MAX      = 18;

  // end of run: seven-stage pipe, so this drain limit is plenty
  localparam int unsigned DRAIN_LIMIT  = 200;
  localparam int unsigned SETTLE       = 20;
  localparam int unsigned WATCHDOG     = 2000000;
  localparam int unsigned PRINT_LIMIT  = 100;

  // exact fixed point: everything is in units of 1/60e6
  localparam longint unsigned UNIT_DENOM = 64'd60000000;
  localparam longint unsigned CODE_FULL  = 64'd255;

  // one pending colour, with the idle cycles to insert ahead of it
  typedef struct {
    hsv_t        color;
    int unsigned gap;
    bit          drain;  // hold this beat until every result is back
  } color_beat_t;

  // one expected result, with its input kept for messages
  typedef struct {
    hsv_t color;
    rgb_t codes;
  } rgb_expect_t;

  logic clk;
  logic rst   = 1'b1;
  logic start = 1'b0;
  logic busy;
  hsv_t hsv   = '0;
  logic done;
  rgb_t rgb;

  color_beat_t color_q[$];
  rgb_expect_t rgb_expect_q[$];
  bit          beat_taken     = 1'b0;
  int unsigned mismatch_count = 0;

  hsv_to_rgb_converter_unit DUT (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .hsv   (hsv),
    .done  (done),
    .rgb   (rgb)
  );

  // 12 unit period
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // --------------------------------------------------------------------------
  // prediction: exact integer hsv to rgb
  // --------------------------------------------------------------------------
  function automatic rgb_t hsv_to_rgb_codes(input hsv_t color);
    longint unsigned hue, sat, val, fold, fold_dist;
    longint unsigned val_units, chroma, second, offset;
    longint unsigned red_units, green_units, blue_units;
    sector_t         sector;
    rgb_t            codes;

    // clamp percentages, wrap hue once around the circle
    sat = (color.sat_pct > PCT_MAX) ? PCT_MAX : color.sat_pct;
    val = (color.val_pct > PCT_MAX) ? PCT_MAX : color.val_pct;
    hue = longint'(color.hue_centideg) % FULL_TURN;

    // distance of the hue from the middle of its 120 degree fold
    fold      = hue % (2 * SECTOR_SPAN);
    fold_dist = (fold >= SECTOR_SPAN) ? fold - SECTOR_SPAN : SECTOR_SPAN - fold;

    val_units = val * VAL_UNIT;
    chroma    = sat * val * SECTOR_SPAN;
    second    = sat * val * (SECTOR_SPAN - fold_dist);
    offset    = val_units - chroma;

    // an exact multiple of 60 degrees starts its own sector
    sector = sector_t'(3'(hue / SECTOR_SPAN));
    case (sector)
      SEC_RED_YELLOW: begin
        red_units = chroma; green_units = second; blue_units = 0;
      end
      SEC_YELLOW_GREEN: begin
        red_units = second; green_units = chroma; blue_units = 0;
      end
      SEC_GREEN_CYAN: begin
        red_units = 0; green_units = chroma; blue_units = second;
      end
      SEC_CYAN_BLUE: begin
        red_units = 0; green_units = second; blue_units = chroma;
      end
      SEC_BLUE_MAGENTA: begin
        red_units = second; green_units = 0; blue_units = chroma;
      end
      default: begin
        red_units = chroma; green_units = 0; blue_units = second;
      end
    endcase

    // truncate once at the end
    codes.red   = 8'(((red_units + offset) * CODE_FULL) / UNIT_DENOM);
    codes.green = 8'(((green_units + offset) * CODE_FULL) / UNIT_DENOM);
    codes.blue  = 8'(((blue_units + offset) * CODE_FULL) / UNIT_DENOM);
    return codes;
  endfunction

  // one line per mismatch, capped so a broken build stays readable
  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("mismatch at %0t: %s", $time, what);
    end
    mismatch_count++;
  endtask

  task automatic queue_color(input int unsigned hue, input int unsigned sat,
                             input int unsigned val, input int unsigned gap = 0,
                             input bit drain = 1'b0);
    color_beat_t beat;
    beat.color.hue_centideg = 16'(hue);
    beat.color.sat_pct      = 7'(sat);
    beat.color.val_pct      = 7'(val);
    beat.gap                = gap;
    beat.drain              = drain;
    color_q.push_back(beat);
  endtask

  // --------------------------------------------------------------------------
  // driver: changes inputs on the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    logic next_start;
    hsv_t next_hsv;

    next_start = start;
    next_hsv   = hsv;
    // a beat still on offer and not yet taken stays as it is
    if (!rst && !(start && !beat_taken)) begin
      next_start = 1'b0;
      // junk on the bus while idle, the converter must ignore it
      next_hsv   = hsv_t'(30'($urandom));
      if (color_q.size() > 0) begin
        if (color_q[0].gap > 0) begin
          color_q[0].gap = color_q[0].gap - 1;
        end else if (!(color_q[0].drain && rgb_expect_q.size() > 0)) begin
          next_start = 1'b1;
          next_hsv   = color_q[0].color;
          void'(color_q.pop_front());
        end
      end
    end
    start <= next_start;
    hsv   <= next_hsv;
  end

  // --------------------------------------------------------------------------
  // monitor: samples the handshake and results on the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    rgb_expect_t want;

    beat_taken = 1'b0;
    if (!rst) begin
      // record the beat first, so the fifo order holds for any latency
      if (start && !busy) begin
        beat_taken = 1'b1;
        want.color = hsv;
        want.codes = hsv_to_rgb_codes(hsv);
        rgb_expect_q.push_back(want);
      end
      if (done) begin
        if (rgb_expect_q.size() == 0) begin
          report_mismatch($sformatf("result %0d/%0d/%0d with nothing pending",
                                    rgb.red, rgb.green, rgb.blue));
        end else begin
          want = rgb_expect_q.pop_front();
          if (rgb.red !== want.codes.red)
            report_mismatch($sformatf("h=%0d s=%0d v=%0d red %0d, want %0d",
                                      want.color.hue_centideg, want.color.sat_pct,
                                      want.color.val_pct, rgb.red, want.codes.red));
          if (rgb.green !== want.codes.green)
            report_mismatch($sformatf("h=%0d s=%0d v=%0d green %0d, want %0d",
                                      want.color.hue_centideg, want.color.sat_pct,
                                      want.color.val_pct, rgb.green, want.codes.green));
          if (rgb.blue !== want.codes.blue)
            report_mismatch($sformatf("h=%0d s=%0d v=%0d blue %0d, want %0d",
                                      want.color.hue_centideg, want.color.sat_pct,
                                      want.color.val_pct, rgb.blue, want.codes.blue));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int unsigned n, i, mode, odds, kind, gap, hue, sat, val;
    bit          drain;

    // directed: primaries, secondaries, sector edges, midpoints
    queue_color(0, 0, 0);
    queue_color(0, 100, 100);
    queue_color(6000, 100, 100);
    queue_color(12000, 100, 100);
    queue_color(18000, 100, 100);
    queue_color(24000, 100, 100);
    queue_color(30000, 100, 100);
    queue_color(35999, 100, 100);
    queue_color(5999, 100, 100);
    queue_color(3000, 100, 100);
    queue_color(9000, 50, 80);
    queue_color(20000, 1, 100);
    queue_color(33000, 100, 1);
    queue_color(1, 37, 63);
    // out of range: hue wrap, saturation and value clamp, every bit set
    queue_color(36000, 100, 100);
    queue_color(65535, 127, 127);
    queue_color(0, 127, 0);
    queue_color(21000, 0, 127);
    queue_color(15000, 101, 100);
    queue_color(27000, 100, 101);

    mode = 0;
    for (n = 0; n < RANDOM_BEATS; n++) begin
      // idle pattern changes every 50 beats, including runs with none
      if (n % 50 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0:       odds = 0;
        1:       odds = 12;
        2:       odds = 35;
        default: odds = 65;
      endcase
      gap = 0;
      if (n < RANDOM_BEATS - QUIET_TAIL && $urandom_range(0, 99) < odds)
        gap = $urandom_range(1, GAP_MAX);
      // let the pipe run dry twice
      drain = (n == 0 || n == RANDOM_BEATS / 2);

      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        // ordinary in-range colour
        hue = $urandom_range(0, 35999);
        sat = $urandom_range(0, 100);
        val = $urandom_range(0, 100);
      end else if (kind == 6) begin
        // near a sector edge, with 36000 and 36001 wrapping past zero
        hue = $urandom_range(0, 6) * 6000 + $urandom_range(0, 2) - 1;
        sat = $urandom_range(0, 100);
        val = $urandom_range(0, 100);
      end else if (kind == 7) begin
        // corner percentages
        hue = $urandom_range(0, 35999);
        sat = ($urandom_range(0, 1) != 0) ? $urandom_range(99, 100) : $urandom_range(0, 1);
        val = ($urandom_range(0, 1) != 0) ? $urandom_range(99, 100) : $urandom_range(0, 1);
      end else begin
        // raw full-width fields
        hue = $urandom_range(0, 65535);
        sat = $urandom_range(0, 127);
        val = $urandom_range(0, 127);
      end
      queue_color(hue, sat, val, gap, drain);
    end

    // reset held from the start, released on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // all beats handed over
    while (color_q.size() > 0 || start) @(posedge clk);
    // results still in the pipe
    for (i = 0; i < DRAIN_LIMIT && rgb_expect_q.size() > 0; i++) @(posedge clk);
    if (rgb_expect_q.size() > 0)
      report_mismatch($sformatf("%0d results never came", rgb_expect_q.size()));
    // any stray strobe after this is caught by the monitor
    repeat (SETTLE) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // hard stop if the run hangs
  initial begin
    #(WATCHDOG);
    $display("TB_ERROR");
    $finish;
  end

endmodule
